// ===== sv/swb_pkg.sv =====
// ----------------------------------------------------------------------------
// swb_pkg
// Shared types and constants of the single-wire bus master.
// ----------------------------------------------------------------------------
package swb_pkg;

  localparam int CFG_NUM = 8;
  localparam int CFG_W   = 10;
  localparam int CFG_AW  = 3;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_RST_LOW   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PRES_WAIT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_RST_TAIL  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_WR1_LOW   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_WR_SLOT   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_RD_LOW    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_RD_SAMPLE = 3'd6;
  localparam logic [CFG_AW-1:0] REG_RD_TAIL   = 3'd7;

  typedef logic [CFG_NUM-1:0][CFG_W-1:0] cfg_arr_t;

  localparam cfg_arr_t CFG_RESET = {
    10'd50, 10'd5, 10'd5, 10'd60, 10'd10, 10'd500, 10'd70, 10'd500
  };

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       rejected;
    logic       presence_found;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } res_t;

endpackage

// ===== sv/swb_cfg.sv =====
// ----------------------------------------------------------------------------
// swb_cfg
// Timing register file, loaded with default bus timings at reset.
// ----------------------------------------------------------------------------
module swb_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [swb_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [swb_pkg::CFG_W-1:0]  cfg_wdata,
  output swb_pkg::cfg_arr_t          cfg_o
);

  swb_pkg::cfg_arr_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= swb_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r[cfg_addr] <= cfg_wdata;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== sv/swb_seq.sv =====
// ----------------------------------------------------------------------------
// swb_seq
// Bus sequencer: reset/presence, write and read slot timing, one tick per step.
// ----------------------------------------------------------------------------
module swb_seq #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  swb_pkg::item_t    item,
  input  swb_pkg::cfg_arr_t cfg,
  output swb_pkg::res_t     res
);

  localparam int LW = ((COUNT_WIDTH > swb_pkg::CFG_W) ? COUNT_WIDTH : swb_pkg::CFG_W) + 1;
  localparam logic [LW-1:0] SPAN = LW'(1) << COUNT_WIDTH;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_SAMPLE, PH_RST_TAIL,
    PH_WR_LOW, PH_WR_HIGH, PH_RD_LOW, PH_RD_WAIT, PH_RD_SAMPLE, PH_RD_TAIL
  } phase_t;

  phase_t                 phase_r, phase_nxt, ph_start;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt, tick_inc;
  logic [2:0]             bit_r, bit_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [7:0]             rx_r, rx_nxt;
  logic                   pres_r, pres_nxt;
  logic [swb_pkg::CFG_W-1:0] len_raw;
  logic [LW-1:0]          len_w, len_eff, tick_p1;
  logic                   last, cur_bit, drive, done, rej;

  always_comb begin
    ph_start  = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    rej = (phase_r != PH_IDLE) && (item.command != swb_pkg::CMD_TICK);
    if (phase_r == PH_IDLE && item.command != swb_pkg::CMD_TICK) begin
      tick_nxt = '0;
      bit_nxt  = '0;
      case (item.command)
        swb_pkg::CMD_RESET: ph_start = PH_RST_LOW;
        swb_pkg::CMD_WRITE: begin
          shift_nxt = item.tx_byte;
          ph_start  = PH_WR_LOW;
        end
        default: begin
          shift_nxt = '0;
          ph_start  = PH_RD_LOW;
        end
      endcase
    end

    cur_bit = shift_nxt[bit_nxt];
    case (ph_start)
      PH_RST_LOW:  len_raw = cfg[swb_pkg::REG_RST_LOW];
      PH_RST_WAIT: len_raw = cfg[swb_pkg::REG_PRES_WAIT];
      PH_RST_TAIL: len_raw = cfg[swb_pkg::REG_RST_TAIL];
      PH_WR_LOW:   len_raw = cur_bit ? cfg[swb_pkg::REG_WR1_LOW] : cfg[swb_pkg::REG_WR_SLOT];
      PH_WR_HIGH: begin
        if (cur_bit && cfg[swb_pkg::REG_WR_SLOT] > cfg[swb_pkg::REG_WR1_LOW])
          len_raw = cfg[swb_pkg::REG_WR_SLOT] - cfg[swb_pkg::REG_WR1_LOW];
        else
          len_raw = swb_pkg::CFG_W'(1);
      end
      PH_RD_LOW:   len_raw = cfg[swb_pkg::REG_RD_LOW];
      PH_RD_WAIT:  len_raw = cfg[swb_pkg::REG_RD_SAMPLE];
      PH_RD_TAIL:  len_raw = cfg[swb_pkg::REG_RD_TAIL];
      default:     len_raw = swb_pkg::CFG_W'(1);
    endcase

    len_w   = (len_raw == '0) ? LW'(1) : LW'(len_raw);
    len_eff = (len_w > SPAN) ? SPAN : len_w;
    tick_p1 = LW'(tick_nxt) + LW'(1);
    last    = tick_p1 >= len_eff;
    tick_inc = last ? '0 : tick_p1[COUNT_WIDTH-1:0];

    phase_nxt = ph_start;
    rx_nxt    = rx_r;
    pres_nxt  = pres_r;
    drive     = 1'b0;
    done      = 1'b0;
    case (ph_start)
      PH_RST_LOW: begin
        drive    = 1'b1;
        tick_nxt = tick_inc;
        if (last) phase_nxt = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        tick_nxt = tick_inc;
        if (last) phase_nxt = PH_RST_SAMPLE;
      end
      PH_RST_SAMPLE: begin
        pres_nxt  = ~item.line_level;
        tick_nxt  = '0;
        phase_nxt = PH_RST_TAIL;
      end
      PH_RST_TAIL: begin
        tick_nxt = tick_inc;
        if (last) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      PH_WR_LOW: begin
        drive    = 1'b1;
        tick_nxt = tick_inc;
        if (last) phase_nxt = PH_WR_HIGH;
      end
      PH_WR_HIGH: begin
        tick_nxt = tick_inc;
        if (last) begin
          if (bit_nxt == 3'd7) begin
            bit_nxt   = '0;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            bit_nxt   = bit_nxt + 3'd1;
            phase_nxt = PH_WR_LOW;
          end
        end
      end
      PH_RD_LOW: begin
        drive    = 1'b1;
        tick_nxt = tick_inc;
        if (last) phase_nxt = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        tick_nxt = tick_inc;
        if (last) phase_nxt = PH_RD_SAMPLE;
      end
      PH_RD_SAMPLE: begin
        if (item.line_level) shift_nxt[bit_nxt] = 1'b1;
        tick_nxt  = '0;
        phase_nxt = PH_RD_TAIL;
      end
      PH_RD_TAIL: begin
        tick_nxt = tick_inc;
        if (last) begin
          if (bit_nxt == 3'd7) begin
            bit_nxt   = '0;
            phase_nxt = PH_IDLE;
            rx_nxt    = shift_nxt;
            done      = 1'b1;
          end else begin
            bit_nxt   = bit_nxt + 3'd1;
            phase_nxt = PH_RD_LOW;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
      end
    endcase

    res.drive_low      = drive;
    res.busy_res       = (ph_start != PH_IDLE);
    res.done_res       = done;
    res.rx_byte        = rx_nxt;
    res.presence_found = pres_nxt;
    res.rejected       = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      rx_r    <= '0;
      pres_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      rx_r    <= rx_nxt;
      pres_r  <= pres_nxt;
    end
  end

endmodule

// ===== sv/single_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// single_wire_bus_master
// One-wire open-drain bus master stepped by one input transfer per tick.
// ----------------------------------------------------------------------------
// Each input transfer is one microsecond tick: it carries an optional command
// (tick only, bus reset with presence detect, write byte, read byte), the byte
// to write and the bus level sampled on that tick. Each input transfer yields
// exactly one output transfer with the pull-low drive for that tick, busy and
// done flags, the last received byte, the presence flag and a rejected flag
// for a command sent while a previous one is still running.
// An item waits in the input register, its result in the output register.
// Throughput is one transfer per cycle while out_tready stays high; the step
// logic between the two registers updates the sequencer at the same edge
// that registers the result. Timing registers are written on the cfg_ port;
// the user must do so only while the block is idle, the block does not
// enforce it. Reset (rst_n low, synchronous) empties both registers, idles
// the sequencer and restores the default timings. When out_tready is low
// the result is held and the input register keeps one more item; in_tready
// drops once both are full, so no transfer is lost.
// ----------------------------------------------------------------------------
module single_wire_bus_master #(
  parameter int COUNT_WIDTH = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] command, [9:2] tx_byte, [10] line_level, [15:11] zero
  input  logic [swb_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [10:3] rx_byte,
  // [11] presence_found, [12] rejected, [15:13] zero
  output logic [swb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [swb_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [swb_pkg::CFG_W-1:0]       cfg_wdata
);

  logic              in_v_r, out_v_r, fire;
  swb_pkg::item_t    in_d_r;
  swb_pkg::res_t     out_d_r, res;
  swb_pkg::cfg_arr_t cfg;

  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (fire) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_d_r.command    <= in_tdata[1:0];
      in_d_r.tx_byte    <= in_tdata[9:2];
      in_d_r.line_level <= in_tdata[10];
    end
    if (fire) out_d_r <= res;
  end

  swb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  swb_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .item    (in_d_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_d_r};

endmodule

// ===== sv/swb_chk.sv =====
// ----------------------------------------------------------------------------
// swb_chk
// Port-level checks of the single-wire bus master.
// ----------------------------------------------------------------------------
module swb_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic [swb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[2] || out_tdata[1])
    else $error("done without busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[0] || out_tdata[1])
    else $error("bus driven while idle");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not empty after reset");

endmodule

bind single_wire_bus_master swb_chk u_swb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
